// ----- rtl/hue_range_recolor_defines.svh -----
// assertion macros for the hue recolor block
`ifndef HUE_RANGE_RECOLOR_DEFINES_SVH
`define HUE_RANGE_RECOLOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HRR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HRR_ASSERT_IMP(lbl, ante, cons, msg)
`define HRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/hrr_pkg.sv -----
`default_nettype none
package hrr_pkg;
    localparam int DW = 8;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [20:0] RECIP15 = 21'h111111;
    localparam logic [1:0] REG_HUE_LOW   = 2'd0;
    localparam logic [1:0] REG_HUE_HIGH  = 2'd1;
    localparam logic [1:0] REG_HUE_SHIFT = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] mx;
        logic       gray;
    } t_pix;
endpackage
`default_nettype wire

// ----- rtl/hrr_front.sv -----
`default_nettype none
module hrr_front #(
    parameter int FRAC_BITS = 6,
    parameter int STEPS     = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [7:0]                i_red,
    input  wire  [7:0]                i_green,
    input  wire  [7:0]                i_blue,
    input  wire  [7:0]                i_alpha,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [STEPS+7:0]          o_num_hue,
    output logic [7:0]                o_den_hue,
    output logic [STEPS+7:0]          o_num_sat,
    output logic [7:0]                o_den_sat,
    output hrr_pkg::t_pix             o_pix
);
    import hrr_pkg::*;
    localparam int XW = STEPS + DW;

    logic              r_v1, r_v2, en1, en2;
    t_pix              r1_pix, r2_pix, n1_pix;
    logic [8:0]        r1_base, n1_base;
    logic signed [8:0] r1_num, n1_num;
    logic [7:0]        r1_d, n1_mn;
    logic [XW-1:0]     r2_num_hue, r2_num_sat, n2_num_hue;
    logic [16:0]       prod_bd;
    logic signed [18:0] sixty_n, acc;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // max, min and hue sector
    always_comb begin
        n1_pix.red   = i_red;
        n1_pix.green = i_green;
        n1_pix.blue  = i_blue;
        n1_pix.alpha = i_alpha;
        n1_pix.mx    = i_red;
        n1_mn        = i_red;
        if (i_green > n1_pix.mx) n1_pix.mx = i_green;
        if (i_blue > n1_pix.mx) n1_pix.mx = i_blue;
        if (i_green < n1_mn) n1_mn = i_green;
        if (i_blue < n1_mn) n1_mn = i_blue;
        n1_pix.gray = (n1_pix.mx == n1_mn);
        if (n1_pix.mx == i_red) begin
            n1_base = (i_green >= i_blue) ? 9'd0 : 9'd360;
            n1_num  = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (n1_pix.mx == i_green) begin
            n1_base = 9'd120;
            n1_num  = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n1_base = 9'd240;
            n1_num  = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_comb begin
        prod_bd    = 17'(r1_base) * 17'(r1_d);
        sixty_n    = 19'({{10{r1_num[8]}}, r1_num}) * 19'sd60;
        acc        = $signed({2'b00, prod_bd}) + sixty_n;
        n2_num_hue = XW'(acc[16:0]) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pix  <= n1_pix;
            r1_base <= n1_base;
            r1_num  <= n1_num;
            r1_d    <= n1_pix.mx - n1_mn;
        end
        if (en2) begin
            r2_pix     <= r1_pix;
            r2_num_hue <= n2_num_hue;
            r2_num_sat <= XW'(r1_d) << 16;
            o_den_hue  <= r1_d;
        end
    end

    assign o_valid   = r_v2;
    assign o_num_hue = r2_num_hue;
    assign o_num_sat = r2_num_sat;
    assign o_den_sat = r2_pix.mx;
    assign o_pix     = r2_pix;
endmodule
`default_nettype wire

// ----- rtl/hrr_divpipe.sv -----
`default_nettype none
module hrr_divpipe #(
    parameter int STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [STEPS+7:0]    i_num_a,
    input  wire  [7:0]          i_den_a,
    input  wire  [STEPS+7:0]    i_num_b,
    input  wire  [7:0]          i_den_b,
    input  hrr_pkg::t_pix       i_pix,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [STEPS-1:0]    o_quo_a,
    output logic [STEPS-1:0]    o_quo_b,
    output hrr_pkg::t_pix       o_pix
);
    import hrr_pkg::*;
    localparam int XW = STEPS + DW;

    // one restoring step: upper bits are the remainder, quotient bits enter at the bottom
    function automatic logic [XW-1:0] div_step(input logic [XW-1:0] x, input logic [DW-1:0] den);
        logic [DW:0] t;
        logic [DW:0] nr;
        logic        ge;
        t  = {x[XW-1:STEPS], x[STEPS-1]};
        ge = (t >= {1'b0, den});
        nr = ge ? (t - {1'b0, den}) : t;
        return {nr[DW-1:0], x[STEPS-2:0], ge};
    endfunction

    logic [XW-1:0] r_xa [STEPS];
    logic [XW-1:0] r_xb [STEPS];
    logic [DW-1:0] r_da [STEPS];
    logic [DW-1:0] r_db [STEPS];
    t_pix          r_pix [STEPS];
    logic [STEPS-1:0] r_v, en;

    always_comb begin
        en[STEPS-1] = !r_v[STEPS-1] || i_ready;
        for (int k = STEPS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [XW-1:0] src_a, src_b;
        logic [DW-1:0] src_da, src_db;
        t_pix          src_pix;
        logic          src_v;
        if (k == 0) begin : g_first
            assign src_a   = i_num_a;
            assign src_b   = i_num_b;
            assign src_da  = i_den_a;
            assign src_db  = i_den_b;
            assign src_pix = i_pix;
            assign src_v   = i_valid;
        end else begin : g_next
            assign src_a   = r_xa[k-1];
            assign src_b   = r_xb[k-1];
            assign src_da  = r_da[k-1];
            assign src_db  = r_db[k-1];
            assign src_pix = r_pix[k-1];
            assign src_v   = r_v[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= src_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_xa[k]  <= div_step(src_a, src_da);
                r_xb[k]  <= div_step(src_b, src_db);
                r_da[k]  <= src_da;
                r_db[k]  <= src_db;
                r_pix[k] <= src_pix;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_quo_a = r_xa[STEPS-1][STEPS-1:0];
    assign o_quo_b = r_xb[STEPS-1][STEPS-1:0];
    assign o_pix   = r_pix[STEPS-1];
endmodule
`default_nettype wire

// ----- rtl/hrr_hsv2rgb.sv -----
`default_nettype none
module hrr_hsv2rgb #(
    parameter int FRAC_BITS = 6
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [FRAC_BITS+8:0]    i_hue,
    input  wire  [16:0]             i_sat,
    input  hrr_pkg::t_pix           i_pix,
    input  wire  [8:0]              i_hue_low,
    input  wire  [8:0]              i_hue_high,
    input  wire  [8:0]              i_hue_shift,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic [7:0]              o_alpha,
    output logic                    o_recolored
);
    import hrr_pkg::*;
    localparam int HW = FRAC_BITS + 9;
    localparam int MW = FRAC_BITS + 6;
    localparam int NSTG = 6;
    localparam logic [HW:0]   FULL  = (HW+1)'(360) << FRAC_BITS;
    localparam logic [HW-1:0] SIXTY = HW'(60) << FRAC_BITS;
    localparam logic [2:0] SEC_R_TO_Y = 3'd0;
    localparam logic [2:0] SEC_Y_TO_G = 3'd1;
    localparam logic [2:0] SEC_G_TO_C = 3'd2;
    localparam logic [2:0] SEC_C_TO_B = 3'd3;
    localparam logic [2:0] SEC_B_TO_M = 3'd4;

    function automatic logic [7:0] chan(input logic [16:0] x);
        logic [24:0] p;
        p = ({x, 8'd0}) - 25'(x);
        return (p[24:16] > 9'd255) ? 8'd255 : p[23:16];
    endfunction

    logic [NSTG-1:0] r_v, en;
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: range test, shift with wrap, sector and remainder
    logic [HW:0]   n_sum;
    logic [HW-1:0] n_hs, n_off;
    logic [2:0]    n_sec;
    logic [MW-1:0] n_m;
    logic          n_sel;
    logic [19:0]   r1_y;
    logic [2:0]    r1_sec, r2_sec, r3_sec, r4_sec, r5_sec;
    logic [16:0]   r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [16:0]   r1_s, r2_s, r3_s;
    t_pix          r1_pix, r2_pix, r3_pix, r4_pix, r5_pix;
    logic          r1_sel, r2_sel, r3_sel, r4_sel, r5_sel;

    always_comb begin
        n_sel = !i_pix.gray && (i_hue >= (HW'(i_hue_low) << FRAC_BITS))
                && (i_hue <= (HW'(i_hue_high) << FRAC_BITS));
        n_sum = (HW+1)'(i_hue) + ((HW+1)'(i_hue_shift) << FRAC_BITS);
        if (n_sum >= (FULL << 1)) n_sum = n_sum - (FULL << 1);
        else if (n_sum >= FULL) n_sum = n_sum - FULL;
        n_hs = n_sum[HW-1:0];
        if (n_hs >= HW'(5 * SIXTY)) begin
            n_sec = 3'd5;
            n_off = HW'(5 * SIXTY);
        end else if (n_hs >= HW'(4 * SIXTY)) begin
            n_sec = 3'd4;
            n_off = HW'(4 * SIXTY);
        end else if (n_hs >= HW'(3 * SIXTY)) begin
            n_sec = 3'd3;
            n_off = HW'(3 * SIXTY);
        end else if (n_hs >= HW'(2 * SIXTY)) begin
            n_sec = 3'd2;
            n_off = HW'(2 * SIXTY);
        end else if (n_hs >= SIXTY) begin
            n_sec = 3'd1;
            n_off = SIXTY;
        end else begin
            n_sec = 3'd0;
            n_off = '0;
        end
        n_m = MW'(n_hs - n_off);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_y   <= 20'(n_m) << (14 - FRAC_BITS);
            r1_sec <= n_sec;
            r1_v   <= {1'b0, i_pix.mx, i_pix.mx} + 17'(|i_pix.mx);
            r1_s   <= i_sat;
            r1_pix <= i_pix;
            r1_sel <= n_sel;
        end
    end

    // stage 2: reciprocal estimate of y / 15, and p
    logic [40:0] n_qprod;
    logic [33:0] n_pprod;
    logic [16:0] r2_q0, r2_p, r3_p, r4_p, r5_p;
    logic [19:0] r2_y;
    assign n_qprod = 41'(r1_y) * 41'(RECIP15);
    assign n_pprod = 34'(r1_v) * 34'(ONE_Q16 - r1_s);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_q0  <= n_qprod[40:24];
            r2_y   <= r1_y;
            r2_p   <= n_pprod[32:16];
            r2_sec <= r1_sec;
            r2_v   <= r1_v;
            r2_s   <= r1_s;
            r2_pix <= r1_pix;
            r2_sel <= r1_sel;
        end
    end

    // stage 3: correct the estimate to get f
    logic [20:0] n_rem;
    logic [15:0] r3_f;
    assign n_rem = 21'(r2_y) - 21'(r2_q0) * 21'd15;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_f   <= 16'(r2_q0 + 17'(n_rem >= 21'd15));
            r3_p   <= r2_p;
            r3_sec <= r2_sec;
            r3_v   <= r2_v;
            r3_s   <= r2_s;
            r3_pix <= r2_pix;
            r3_sel <= r2_sel;
        end
    end

    // stage 4: f*s and (1-f)*s
    logic [32:0] n_fs, n_gs;
    logic [15:0] r4_fs;
    logic [16:0] r4_gs;
    assign n_fs = 33'(r3_f) * 33'(r3_s);
    assign n_gs = 33'(ONE_Q16 - 17'(r3_f)) * 33'(r3_s);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_fs  <= n_fs[31:16];
            r4_gs  <= n_gs[32:16];
            r4_p   <= r3_p;
            r4_sec <= r3_sec;
            r4_v   <= r3_v;
            r4_pix <= r3_pix;
            r4_sel <= r3_sel;
        end
    end

    // stage 5: q and t
    logic [33:0] n_qq, n_tt;
    logic [16:0] r5_q, r5_t;
    assign n_qq = 34'(r4_v) * 34'(ONE_Q16 - 17'(r4_fs));
    assign n_tt = 34'(r4_v) * 34'(ONE_Q16 - r4_gs);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_q   <= n_qq[32:16];
            r5_t   <= n_tt[32:16];
            r5_p   <= r4_p;
            r5_sec <= r4_sec;
            r5_v   <= r4_v;
            r5_pix <= r4_pix;
            r5_sel <= r4_sel;
        end
    end

    // stage 6: sector select and channel scaling
    logic [16:0] n_ro, n_go, n_bo;
    always_comb begin
        case (r5_sec)
            SEC_R_TO_Y: begin n_ro = r5_v; n_go = r5_t; n_bo = r5_p; end
            SEC_Y_TO_G: begin n_ro = r5_q; n_go = r5_v; n_bo = r5_p; end
            SEC_G_TO_C: begin n_ro = r5_p; n_go = r5_v; n_bo = r5_t; end
            SEC_C_TO_B: begin n_ro = r5_p; n_go = r5_q; n_bo = r5_v; end
            SEC_B_TO_M: begin n_ro = r5_t; n_go = r5_p; n_bo = r5_v; end
            default:    begin n_ro = r5_v; n_go = r5_p; n_bo = r5_q; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            o_red       <= r5_sel ? chan(n_ro) : r5_pix.red;
            o_green     <= r5_sel ? chan(n_go) : r5_pix.green;
            o_blue      <= r5_sel ? chan(n_bo) : r5_pix.blue;
            o_alpha     <= r5_pix.alpha;
            o_recolored <= r5_sel;
        end
    end

    assign o_valid = r_v[NSTG-1];
endmodule
`default_nettype wire

// ----- rtl/hue_range_recolor.sv -----
// hue_range_recolor: takes one rgba pixel per beat, finds its hsv hue and, when the
// hue lies inside [hue_low, hue_high], adds hue_shift (wrapping at 360 degrees) and
// converts back to rgb; gray pixels and pixels outside the range pass unchanged, alpha
// always passes, and tuser flags recolored pixels. one pixel per clock is sustained;
// hue and saturation are formed by the bit-per-stage divider. the pipeline stalls only
// when the output is held and every stage is full; configuration should be written
// while no beat is in flight.
`default_nettype none
`include "hue_range_recolor_defines.svh"
module hue_range_recolor #(
    parameter int FRAC_BITS = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input pixel beat
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in from bit 0 up
    // output pixel beat
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out from bit 0 up
    output logic        m_tuser,   // recolored
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hrr_pkg::*;
    // saturation reaches 1.0 (17 bits) when the smallest channel is zero
    localparam int STEPS = (FRAC_BITS + 9 > 17) ? FRAC_BITS + 9 : 17;

    // configuration registers
    logic [8:0] r_hue_low, r_hue_high, r_hue_shift;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low   <= 9'd0;
            r_hue_high  <= 9'd360;
            r_hue_shift <= 9'd0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HUE_LOW:   r_hue_low   <= pwdata[8:0];
                REG_HUE_HIGH:  r_hue_high  <= pwdata[8:0];
                REG_HUE_SHIFT: r_hue_shift <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HUE_LOW:   prdata = 32'(r_hue_low);
            REG_HUE_HIGH:  prdata = 32'(r_hue_high);
            REG_HUE_SHIFT: prdata = 32'(r_hue_shift);
            default:       prdata = '0;
        endcase
    end

    // front: max/min, sector and dividends
    logic               f_valid, f_ready;
    logic [STEPS+7:0]   f_num_hue, f_num_sat;
    logic [7:0]         f_den_hue, f_den_sat;
    t_pix               f_pix;

    hrr_front #(.FRAC_BITS(FRAC_BITS), .STEPS(STEPS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_tvalid), .o_ready(s_tready),
        .i_red(s_tdata[7:0]), .i_green(s_tdata[15:8]),
        .i_blue(s_tdata[23:16]), .i_alpha(s_tdata[31:24]),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_num_hue(f_num_hue), .o_den_hue(f_den_hue),
        .o_num_sat(f_num_sat), .o_den_sat(f_den_sat),
        .o_pix(f_pix)
    );

    // hue = num / d and saturation = (d << 16) / max, one quotient bit per stage
    logic               d_valid, d_ready;
    logic [STEPS-1:0]   d_hue, d_sat;
    t_pix               d_pix;

    hrr_divpipe #(.STEPS(STEPS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready),
        .i_num_a(f_num_hue), .i_den_a(f_den_hue),
        .i_num_b(f_num_sat), .i_den_b(f_den_sat),
        .i_pix(f_pix),
        .o_valid(d_valid), .i_ready(d_ready),
        .o_quo_a(d_hue), .o_quo_b(d_sat),
        .o_pix(d_pix)
    );

    // shift, back conversion and output register
    hrr_hsv2rgb #(.FRAC_BITS(FRAC_BITS)) u_hsv2rgb (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(d_valid), .o_ready(d_ready),
        .i_hue(d_hue[FRAC_BITS+8:0]), .i_sat(d_sat[16:0]), .i_pix(d_pix),
        .i_hue_low(r_hue_low), .i_hue_high(r_hue_high), .i_hue_shift(r_hue_shift),
        .o_valid(m_tvalid), .i_ready(m_tready),
        .o_red(m_tdata[7:0]), .o_green(m_tdata[15:8]),
        .o_blue(m_tdata[23:16]), .o_alpha(m_tdata[31:24]),
        .o_recolored(m_tuser)
    );

    // input backpressure only when the whole pipe is full behind a held output
    `HRR_ASSERT_IMP(a_ready_only_when_held, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
    // a register write to hue_high or hue_shift lands in the addressed register
    `HRR_ASSERT_NEXT(a_cfg_high_write, cfg_wr && paddr[3:2] == REG_HUE_HIGH, r_hue_high == $past(pwdata[8:0]), "hue_high write lost")
    `HRR_ASSERT_NEXT(a_cfg_shift_write, cfg_wr && paddr[3:2] == REG_HUE_SHIFT, r_hue_shift == $past(pwdata[8:0]), "hue_shift write lost")
endmodule
`default_nettype wire
